// ----- design/mpfb_pkg.sv -----
// Shared constants and types for the page-organized monochrome frame store.
// Used by mpfb_store and monochrome_page_framebuffer_rect_fill; no dependencies.
package mpfb_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGES          = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGES;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RD_ISSUE,
    ST_RD_CAPTURE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

endpackage

// ----- design/monochrome_page_framebuffer_rect_fill.sv -----
// Top level of the page-organized monochrome frame store with rectangle fill.
// Depends on mpfb_pkg and mpfb_store.
//
//  channel | dir | tdata fields, lowest bit up
//  s_*     | in  | opcode, x_start, x_end, y_start, y_end, byte_index
//  m_*     | out | read_data
//
// Clear writes one store byte per cycle; fill handles each touched store
// byte through a pipelined read-modify-write on the single store read port;
// read passes ST_RD_ISSUE and ST_RD_CAPTURE; empty fill or an unused opcode
// goes to ST_DONE. After reset a clearing pass over all STORE_BYTES (1024)
// bytes runs before the first beat is accepted. One item is worked at a time;
// the next beat is accepted while a result still waits on m_tready.
module monochrome_page_framebuffer_rect_fill (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // opcode[1:0], x_start[9:2], x_end[17:10], y_start[25:18], y_end[33:26],
  // byte_index[43:34], zero fill [47:44]
  input  logic [mpfb_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data[7:0]
  output logic [mpfb_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int AW = mpfb_pkg::ADDR_W;

  mpfb_pkg::state_t  state, state_next;
  mpfb_pkg::wr_req_t wr;

  logic [1:0]    in_opcode;
  logic [7:0]    in_x_start, in_x_end, in_y_start, in_y_end;
  logic [9:0]    in_byte_index;
  logic [8:0]    xe_clip, ye_clip, ye_last_full;
  logic          in_empty;

  logic [AW-1:0] clr_cnt;
  logic          clr_last;
  logic          clr_op;
  logic [7:0]    x, xs, xe_last;
  logic [4:0]    page, ys_page, ye_page;
  logic [2:0]    ys_lo, ye_hi, mask_lo, mask_hi;
  logic [7:0]    issue_mask;
  logic [AW-1:0] page_base;
  logic [AW-1:0] rd_idx;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;
  logic [7:0]    res_data;
  logic          out_free;
  logic          fill_last;

  assign in_opcode     = s_tdata[1:0];
  assign in_x_start    = s_tdata[9:2];
  assign in_x_end      = s_tdata[17:10];
  assign in_y_start    = s_tdata[25:18];
  assign in_y_end      = s_tdata[33:26];
  assign in_byte_index = s_tdata[43:34];

  // clip the exclusive ends to the panel
  assign xe_clip = (9'(in_x_end) > 9'(mpfb_pkg::DISPLAY_WIDTH)) ?
                   9'(mpfb_pkg::DISPLAY_WIDTH) : 9'(in_x_end);
  assign ye_clip = (9'(in_y_end) > 9'(mpfb_pkg::DISPLAY_HEIGHT)) ?
                   9'(mpfb_pkg::DISPLAY_HEIGHT) : 9'(in_y_end);
  assign ye_last_full = ye_clip - 9'd1;
  assign in_empty = (9'(in_x_start) >= xe_clip) || (9'(in_y_start) >= ye_clip);

  assign clr_last  = (clr_cnt == AW'(mpfb_pkg::STORE_BYTES - 1));
  assign fill_last = (x == xe_last) && (page == ye_page);
  assign out_free  = !m_tvalid || m_tready;

  // row mask of the page being issued
  assign mask_lo = (page == ys_page) ? ys_lo : 3'd0;
  assign mask_hi = (page == ye_page) ? ye_hi : 3'd7;
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      issue_mask[n] = (3'(n) >= mask_lo) && (3'(n) <= mask_hi);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mpfb_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = clr_op ? mpfb_pkg::ST_DONE : mpfb_pkg::ST_IDLE;
        end
      end
      mpfb_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (in_opcode)
            mpfb_pkg::OP_CLEAR: state_next = mpfb_pkg::ST_CLEAR;
            mpfb_pkg::OP_FILL:  state_next = in_empty ? mpfb_pkg::ST_DONE : mpfb_pkg::ST_FILL;
            mpfb_pkg::OP_READ:  state_next = mpfb_pkg::ST_RD_ISSUE;
            default:            state_next = mpfb_pkg::ST_DONE;
          endcase
        end
      end
      mpfb_pkg::ST_FILL: begin
        if (fill_last) begin
          state_next = mpfb_pkg::ST_DONE;
        end
      end
      mpfb_pkg::ST_RD_ISSUE:   state_next = mpfb_pkg::ST_RD_CAPTURE;
      mpfb_pkg::ST_RD_CAPTURE: state_next = mpfb_pkg::ST_DONE;
      mpfb_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mpfb_pkg::ST_IDLE;
        end
      end
      default: state_next = mpfb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine and store port control
  always_comb begin
    s_tready = (state == mpfb_pkg::ST_IDLE);
    rd_addr  = rd_idx;
    if (state == mpfb_pkg::ST_FILL) begin
      rd_addr = page_base + AW'(x);
    end
    wr = '0;
    if (wr_pend) begin
      wr.en   = 1'b1;
      wr.addr = wr_addr;
      wr.data = rd_data | wr_mask;
    end else if (state == mpfb_pkg::ST_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = clr_cnt;
      wr.data = 8'h00;
    end
  end

  mpfb_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mpfb_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      clr_op   <= 1'b0;
      wr_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == mpfb_pkg::ST_FILL);
      if (state == mpfb_pkg::ST_CLEAR) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + AW'(1);
      end
      if (s_tvalid && s_tready) begin
        clr_op <= 1'b1;
      end
      if (state == mpfb_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      xs        <= in_x_start;
      x         <= in_x_start;
      xe_last   <= 8'(xe_clip - 9'd1);
      ys_page   <= in_y_start[7:3];
      page      <= in_y_start[7:3];
      ys_lo     <= in_y_start[2:0];
      ye_page   <= ye_last_full[7:3];
      ye_hi     <= ye_last_full[2:0];
      page_base <= AW'(32'(in_y_start[7:3]) * mpfb_pkg::DISPLAY_WIDTH);
      rd_idx    <= AW'(in_byte_index);
      rd_ok     <= (32'(in_byte_index) < mpfb_pkg::STORE_BYTES);
      res_data  <= 8'h00;
    end
    if (state == mpfb_pkg::ST_FILL) begin
      wr_addr <= page_base + AW'(x);
      wr_mask <= issue_mask;
      // advance column, then page
      if (x == xe_last) begin
        x         <= xs;
        page      <= page + 5'd1;
        page_base <= page_base + AW'(mpfb_pkg::DISPLAY_WIDTH);
      end else begin
        x <= x + 8'd1;
      end
    end
    if (state == mpfb_pkg::ST_RD_CAPTURE) begin
      res_data <= rd_ok ? rd_data : 8'h00;
    end
    if (state == mpfb_pkg::ST_DONE && out_free) begin
      m_tdata <= res_data;
    end
  end

`ifndef SYNTHESIS
  // the modify half of a fill always lands on the byte read in the cycle before
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (wr_addr == $past(rd_addr)))
    else $error("fill write-back address differs from the byte read");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == mpfb_pkg::ST_CLEAR) |-> !s_tready)
    else $error("beat accepted during store clear");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == mpfb_pkg::ST_DONE && out_free) |=> (m_tvalid && m_tdata == $past(res_data)))
    else $error("finished item did not present its result");

  a_read_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (state == mpfb_pkg::ST_RD_CAPTURE && !rd_ok) |=> (res_data == 8'h00))
    else $error("read beyond the store returned nonzero data");
`endif

endmodule

// ----- design/mpfb_store.sv -----
// Frame store memory: one write port, one read port with registered read data.
// Depends on mpfb_pkg for depth, address width and the write request struct.
module mpfb_store (
  input  logic                      clk,
  input  mpfb_pkg::wr_req_t         wr,
  input  logic [mpfb_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  logic [7:0] mem [mpfb_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
